// File: hw/rtl/binary_gcd_unit_assert.svh
// ----------------------------------------------------------------------------
// binary gcd unit assertion macros
// shared concurrent assertion wrappers, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef BINARY_GCD_UNIT_ASSERT_SVH
`define BINARY_GCD_UNIT_ASSERT_SVH

// checked only while out of reset
`define BGCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define BGCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/bgcd_pkg.sv
// ----------------------------------------------------------------------------
// bgcd_pkg
// types and constants shared by the binary gcd unit
// ----------------------------------------------------------------------------
package bgcd_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORDER,
        ST_DIV,
        ST_CHKREM,
        ST_STRIPX,
        ST_STRIPY,
        ST_LOOP_CMP,
        ST_LOOP_SWAP,
        ST_LOOP_SHIFT,
        ST_DONE
    } bgcd_state_t;

    typedef struct packed {
        logic             valid;
        logic [WIDTH-1:0] value;
    } bgcd_res_t;

endpackage

// File: hw/rtl/bgcd_core.sv
// ----------------------------------------------------------------------------
// bgcd_core
// sequencer around one shared subtractor: ordering, restoring modulo,
// trailing zero strip, subtract-and-shift loop and power of two restore
// ----------------------------------------------------------------------------
module bgcd_core
    import bgcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic             res_ready,
    output logic             idle,
    output bgcd_res_t        res
);

`include "binary_gcd_unit_assert.svh"

    bgcd_state_t      state_reg, state_next;
    logic [WIDTH-1:0] big_reg, big_next;
    logic [WIDTH-1:0] small_reg, small_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] zx_reg, zx_next;
    logic [CNT_W-1:0] zy_reg, zy_next;

    // shared subtractor
    logic [WIDTH:0]   sub_x, sub_y;
    logic [WIDTH+1:0] sub_d;
    logic             borrow;
    logic [WIDTH-1:0] min_val, max_val;

    always_comb begin
        unique case (state_reg)
            ST_DIV: begin
                sub_x = {rem_reg, big_reg[WIDTH-1]};
                sub_y = {1'b0, small_reg};
            end
            ST_LOOP_SWAP: begin
                sub_x = {1'b0, small_reg};
                sub_y = {1'b0, big_reg};
            end
            default: begin
                sub_x = {1'b0, big_reg};
                sub_y = {1'b0, small_reg};
            end
        endcase
        sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
        borrow = sub_d[WIDTH+1];
    end

    assign min_val = borrow ? big_reg : small_reg;
    assign max_val = borrow ? small_reg : big_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        big_reg   <= big_next;
        small_reg <= small_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        cnt_reg   <= cnt_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
    end

    always_comb begin
        state_next = state_reg;
        big_next   = big_reg;
        small_next = small_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    big_next   = op_a;
                    small_next = op_b;
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER: begin
                if (min_val == '0) begin
                    res_next   = max_val;
                    state_next = ST_DONE;
                end else begin
                    big_next   = max_val;
                    small_next = min_val;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring step per cycle, dividend bits shift out of big
                rem_next = borrow ? sub_x[WIDTH-1:0] : sub_d[WIDTH-1:0];
                big_next = {big_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                    state_next = ST_CHKREM;
                end
            end
            ST_CHKREM: begin
                if (rem_reg == '0) begin
                    res_next   = small_reg;
                    state_next = ST_DONE;
                end else begin
                    big_next   = rem_reg;
                    zx_next    = '0;
                    zy_next    = '0;
                    state_next = ST_STRIPX;
                end
            end
            ST_STRIPX: begin
                if (!big_reg[0]) begin
                    big_next = {1'b0, big_reg[WIDTH-1:1]};
                    zx_next  = zx_reg + 1'b1;
                end else begin
                    state_next = ST_STRIPY;
                end
            end
            ST_STRIPY: begin
                if (!small_reg[0]) begin
                    small_next = {1'b0, small_reg[WIDTH-1:1]};
                    zy_next    = zy_reg + 1'b1;
                end else begin
                    // keep the shared power of two in zx
                    zx_next    = (zx_reg < zy_reg) ? zx_reg : zy_reg;
                    state_next = ST_LOOP_CMP;
                end
            end
            ST_LOOP_CMP: begin
                if (!borrow) begin
                    big_next   = small_reg;
                    small_next = sub_d[WIDTH-1:0];
                    state_next = ST_LOOP_SHIFT;
                end else begin
                    state_next = ST_LOOP_SWAP;
                end
            end
            ST_LOOP_SWAP: begin
                small_next = sub_d[WIDTH-1:0];
                state_next = ST_LOOP_SHIFT;
            end
            ST_LOOP_SHIFT: begin
                if (small_reg == '0) begin
                    res_next   = big_reg << zx_reg;
                    state_next = ST_DONE;
                end else if (!small_reg[0]) begin
                    small_next = {1'b0, small_reg[WIDTH-1:1]};
                end else begin
                    state_next = ST_LOOP_CMP;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.value = res_reg;

    `BGCD_ASSERT(a_start_idle, start |-> (state_reg == ST_IDLE), "request taken while busy")
    `BGCD_ASSERT(a_strip_nonzero, (state_reg == ST_STRIPX) |-> (big_reg != '0), "zero remainder in strip")
    `BGCD_ASSERT(a_loop_odd, (state_reg == ST_LOOP_CMP) |-> (big_reg[0] && small_reg[0]), "even value in loop")
    `BGCD_ASSERT(a_done_handoff, (res.valid && res_ready) |=> (state_reg == ST_IDLE), "result not released")
    `BGCD_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE), "sequencer not idle after reset")

endmodule

// File: hw/rtl/binary_gcd_unit.sv
// Sequence: ordering, restoring modulo, remainder check, trailing zero strip of both values,
// then a subtract-and-shift loop and the done state, which hands the result to the output
// register; a zero operand or a zero remainder ends the sequence early.
// Throughput: one request at a time; s_tready is high only while bgcd_core is idle.
// The output register holds a finished result, so the next request is taken meanwhile.
// Reset: aresetn synchronous active low, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// binary_gcd_unit
// greatest common divisor of two unsigned operands, stream in and out
// ----------------------------------------------------------------------------
module binary_gcd_unit
    import bgcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2*WIDTH-1:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [WIDTH-1:0]   m_tdata   // divisor [31:0]
);

    logic             core_idle;
    logic             res_ready;
    bgcd_res_t        core_res;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [WIDTH-1:0] m_tdata_reg, m_tdata_next;

    bgcd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .op_a      (s_tdata[WIDTH-1:0]),
        .op_b      (s_tdata[2*WIDTH-1:WIDTH]),
        .res_ready (res_ready),
        .idle      (core_idle),
        .res       (core_res)
    );

    assign s_tready  = core_idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (core_res.valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = core_res.value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
